// ===== src/acmm_pkg.sv =====
package acmm_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int GAIN_W     = 18;
  localparam int IDX_W      = 3;
  localparam int REG_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int GAIN_FRAC  = 14;
  localparam int PROD_W     = SAMPLE_W + GAIN_W;

  localparam logic [CFG_IDX_W-1:0] REG_IN_CHANNELS  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_OUT_CHANNELS = CFG_IDX_W'(1);

  localparam logic [REG_W-1:0] IN_CHANNELS_RST  = REG_W'(2);
  localparam logic [REG_W-1:0] OUT_CHANNELS_RST = REG_W'(2);

  typedef enum logic {
    OP_SAMPLE     = 1'b0,
    OP_GAIN_WRITE = 1'b1
  } op_e;

endpackage

// ===== src/acmm_in_if.sv =====
interface acmm_in_if
  import acmm_pkg::*;
();
  logic                       valid;
  logic                       ready;
  op_e                        operation;
  logic signed [SAMPLE_W-1:0] sample;
  logic        [IDX_W-1:0]    gain_row;
  logic        [IDX_W-1:0]    gain_col;
  logic signed [GAIN_W-1:0]   gain_value;

  modport source (
    output valid, operation, sample, gain_row, gain_col, gain_value,
    input  ready
  );

  modport sink (
    input  valid, operation, sample, gain_row, gain_col, gain_value,
    output ready
  );
endinterface

// ===== src/acmm_out_if.sv =====
interface acmm_out_if
  import acmm_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] mixed_sample;
  logic        [IDX_W-1:0]    out_channel;
  logic                       frame_last;
  logic                       saturated;

  modport source (
    output valid, mixed_sample, out_channel, frame_last, saturated,
    input  ready
  );

  modport sink (
    input  valid, mixed_sample, out_channel, frame_last, saturated,
    output ready
  );
endinterface

// ===== src/audio_channel_mix_matrix.sv =====
// Audio channel mixing matrix. Interleaved Q1.23 samples are collected into a frame of
// in_channels samples; once the frame is complete, out_channels results come out in
// channel order, each the saturated, round-half-up Q1.23 dot product of the frame with
// one row of the Q4.14 gain table, with frame_last on the final one. Gain writes and
// samples that do not complete a frame are taken while the mixer is idle. A completing
// sample is followed by out_channels * in_channels products on the single shared
// multiplier, fed by the one read port of the gain memory, and then the pipeline drain,
// before the next transaction is taken. A stalled output freezes the mixing pipeline.
// The gain table reads as zero after reset through per-entry valid bits; no clearing
// pass.
module audio_channel_mix_matrix
  import acmm_pkg::*;
#(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [REG_W-1:0]     cfg_data_i,
  acmm_in_if.sink              in_i,
  acmm_out_if.source           out_o
);

  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);
  localparam int DEPTH  = MAX_CHANNELS * MAX_CHANNELS;
  localparam int AW     = $clog2(DEPTH);
  localparam int ACC_W  = PROD_W + CH_W;
  localparam int RES_W  = ACC_W + 1;

  localparam logic signed [RES_W-1:0] RND_BIAS = RES_W'(1 << (GAIN_FRAC - 1));
  localparam logic signed [RES_W-1:0] Y_MAX    = RES_W'((2 ** (SAMPLE_W - 1)) - 1);
  localparam logic signed [RES_W-1:0] Y_MIN    = RES_W'(-(2 ** (SAMPLE_W - 1)));

  function automatic logic [CNT_W-1:0] clamp_count(input logic [REG_W-1:0] n);
    logic [CNT_W-1:0] r;
    if (n == '0) begin
      r = CNT_W'(1);
    end else if (32'(n) > MAX_CHANNELS) begin
      r = CNT_W'(MAX_CHANNELS);
    end else begin
      r = CNT_W'(n);
    end
    return r;
  endfunction

  // configuration registers
  logic [REG_W-1:0] in_ch_q, out_ch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch_q  <= IN_CHANNELS_RST;
      out_ch_q <= OUT_CHANNELS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_IN_CHANNELS:  in_ch_q  <= cfg_data_i;
        REG_OUT_CHANNELS: out_ch_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // memories
  logic signed [GAIN_W-1:0]   gain_mem  [DEPTH];
  logic signed [SAMPLE_W-1:0] frame_mem [MAX_CHANNELS];
  logic        [DEPTH-1:0]    gain_vld_q;

  logic signed [GAIN_W-1:0]   g_rd_q;
  logic signed [SAMPLE_W-1:0] f_rd_q;
  logic                       gv_q;

  // control and pipeline
  logic [CH_W-1:0]  pos_q;
  logic [CNT_W-1:0] nin_q, nout_q;
  logic             iss_v_q;
  logic [CH_W-1:0]  iss_j_q, iss_k_q;
  logic             s1_v_q, s1_first_q, s1_last_q, s1_lrow_q;
  logic [CH_W-1:0]  s1_j_q;
  logic             s2_v_q, s2_first_q, s2_last_q, s2_lrow_q;
  logic [CH_W-1:0]  s2_j_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic             fin_v_q, fin_lrow_q;
  logic [CH_W-1:0]  fin_j_q;

  logic                       out_v_q, out_last_q, out_sat_q;
  logic [CH_W-1:0]            out_j_q;
  logic signed [SAMPLE_W-1:0] out_y_q;

  logic             mix_busy, in_acc, gain_we, frame_we, frame_done, in_gain_ok;
  logic             stall, en, iss_last_k, iss_last_j;
  logic [AW-1:0]    gw_addr, iss_addr;
  logic [CNT_W-1:0] nin_eff, nout_eff;
  logic signed [GAIN_W-1:0]  g_eff;
  logic signed [RES_W-1:0]   acc_ext, rnd, y_sat;
  logic                      sat;

  assign mix_busy   = iss_v_q | s1_v_q | s2_v_q | fin_v_q;
  assign in_i.ready = !mix_busy;
  assign in_acc     = in_i.valid && in_i.ready;

  assign in_gain_ok = (32'(in_i.gain_row) < MAX_CHANNELS) &&
                      (32'(in_i.gain_col) < MAX_CHANNELS);
  assign gw_addr    = AW'(32'(in_i.gain_row) * MAX_CHANNELS + 32'(in_i.gain_col));
  assign gain_we    = in_acc && (in_i.operation == OP_GAIN_WRITE) && in_gain_ok;
  assign frame_we   = in_acc && (in_i.operation == OP_SAMPLE);

  assign nin_eff    = clamp_count(in_ch_q);
  assign nout_eff   = clamp_count(out_ch_q);
  assign frame_done = (32'(pos_q) + 1) >= 32'(nin_eff);

  assign iss_addr   = AW'(32'(iss_j_q) * MAX_CHANNELS + 32'(iss_k_q));
  assign iss_last_k = (32'(iss_k_q) + 1) == 32'(nin_q);
  assign iss_last_j = (32'(iss_j_q) + 1) == 32'(nout_q);

  assign stall = fin_v_q && out_v_q && !out_o.ready;
  assign en    = !stall;

  always_ff @(posedge clk_i) begin
    if (gain_we) begin
      gain_mem[gw_addr] <= in_i.gain_value;
    end
    if (frame_we) begin
      frame_mem[pos_q] <= in_i.sample;
    end
    if (en) begin
      g_rd_q <= gain_mem[iss_addr];
      f_rd_q <= frame_mem[iss_k_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_vld_q <= '0;
      gv_q       <= 1'b0;
    end else begin
      if (gain_we) begin
        gain_vld_q[gw_addr] <= 1'b1;
      end
      if (en) begin
        gv_q <= gain_vld_q[iss_addr];
      end
    end
  end

  // frame position and issue sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      nin_q   <= CNT_W'(1);
      nout_q  <= CNT_W'(1);
      iss_v_q <= 1'b0;
      iss_j_q <= '0;
      iss_k_q <= '0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      fin_v_q <= 1'b0;
    end else begin
      if (frame_we) begin
        if (frame_done) begin
          pos_q   <= '0;
          nin_q   <= nin_eff;
          nout_q  <= nout_eff;
          iss_v_q <= 1'b1;
          iss_j_q <= '0;
          iss_k_q <= '0;
        end else begin
          pos_q <= pos_q + CH_W'(1);
        end
      end else if (en && iss_v_q) begin
        if (iss_last_k) begin
          iss_k_q <= '0;
          iss_j_q <= iss_j_q + CH_W'(1);
          if (iss_last_j) begin
            iss_v_q <= 1'b0;
          end
        end else begin
          iss_k_q <= iss_k_q + CH_W'(1);
        end
      end
      if (en) begin
        s1_v_q  <= iss_v_q;
        s2_v_q  <= s1_v_q;
        fin_v_q <= s2_v_q && s2_last_q;
      end
    end
  end

  assign g_eff = gv_q ? g_rd_q : '0;

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_first_q <= (iss_k_q == '0);
      s1_last_q  <= iss_last_k;
      s1_lrow_q  <= iss_last_j;
      s1_j_q     <= iss_j_q;
      prod_q     <= f_rd_q * g_eff;
      s2_first_q <= s1_first_q;
      s2_last_q  <= s1_last_q;
      s2_lrow_q  <= s1_lrow_q;
      s2_j_q     <= s1_j_q;
      if (s2_v_q) begin
        acc_q <= s2_first_q ? ACC_W'(prod_q) : acc_q + ACC_W'(prod_q);
      end
      fin_j_q    <= s2_j_q;
      fin_lrow_q <= s2_lrow_q;
    end
  end

  // round half up, then saturate
  always_comb begin
    acc_ext = RES_W'(acc_q);
    rnd     = (acc_ext + RND_BIAS) >>> GAIN_FRAC;
    sat     = 1'b0;
    y_sat   = rnd;
    if (rnd > Y_MAX) begin
      y_sat = Y_MAX;
      sat   = 1'b1;
    end else if (rnd < Y_MIN) begin
      y_sat = Y_MIN;
      sat   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (!out_v_q || out_o.ready) begin
      out_v_q <= fin_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_v_q && !stall) begin
      out_y_q    <= SAMPLE_W'(y_sat);
      out_j_q    <= fin_j_q;
      out_last_q <= fin_lrow_q;
      out_sat_q  <= sat;
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.mixed_sample = out_y_q;
  assign out_o.out_channel  = IDX_W'(out_j_q);
  assign out_o.frame_last   = out_last_q;
  assign out_o.saturated    = out_sat_q;

  // checks
  a_fin_moves_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_v_q && !stall |=> out_v_q)
    else $error("finished row result not moved to output");

  a_last_is_final_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_last_q |-> (32'(out_j_q) + 1) == 32'(nout_q))
    else $error("frame_last on wrong output channel");

  a_gain_no_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gain_we |=> !iss_v_q)
    else $error("gain write started mixing");

  a_frame_starts_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_we && frame_done |=> iss_v_q && iss_j_q == '0 && iss_k_q == '0)
    else $error("completed frame did not start mixing");

endmodule
